@@ rtl/core/lbfam_pkg.sv @@
// lbfam_pkg: types, codes and constants for the lighting-bus frame anomaly monitor
// no dependencies
`timescale 1ns / 1ps
package lbfam_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned MaxFindings = 5;
   localparam int unsigned CsrAddrWidth = 1;
   localparam int unsigned CsrDataWidth = 11;
   localparam logic [10:0] MinutesPerDay = 11'd1440;

   localparam logic [1:0] REQ_FRAME = 2'd0;
   localparam logic [1:0] REQ_LINE  = 2'd1;
   localparam logic [1:0] REQ_LOSS  = 2'd2;

   localparam logic [0:0] CSR_WIN_START = 1'd0;
   localparam logic [0:0] CSR_WIN_END   = 1'd1;

   localparam logic [1:0] SIDE_CTRL   = 2'd1;
   localparam logic [1:0] SIDE_DEVICE = 2'd2;

   localparam logic [3:0] FC_BAD_FRAMING   = 4'd0;
   localparam logic [3:0] FC_COLLISION     = 4'd1;
   localparam logic [3:0] FC_BCAST_OFF     = 4'd2;
   localparam logic [3:0] FC_BCAST_MAX     = 4'd3;
   localparam logic [3:0] FC_COMM_START    = 4'd4;
   localparam logic [3:0] FC_COMM_SEQUENCE = 4'd5;
   localparam logic [3:0] FC_OUTSIDE_WIN   = 4'd6;
   localparam logic [3:0] FC_ADDR_PROG     = 4'd7;
   localparam logic [3:0] FC_RATE_HIGH     = 4'd8;
   localparam logic [3:0] FC_STUCK_LOW     = 4'd9;
   localparam logic [3:0] FC_REPLY_CLASH   = 4'd10;
   localparam logic [3:0] FC_CAPTURE_LOSS  = 4'd11;

   localparam logic [1:0] SEV_LOW     = 2'd0;
   localparam logic [1:0] SEV_MED     = 2'd1;
   localparam logic [1:0] SEV_SERIOUS = 2'd2;
   localparam logic [1:0] SEV_CRIT    = 2'd3;

   localparam logic [7:0] A_TERMINATE  = 8'hA1;
   localparam logic [7:0] A_DTR0       = 8'hA3;
   localparam logic [7:0] A_INITIALISE = 8'hA5;
   localparam logic [7:0] A_RANDOMISE  = 8'hA7;
   localparam logic [7:0] A_COMPARE    = 8'hA9;
   localparam logic [7:0] A_WITHDRAW   = 8'hAB;
   localparam logic [7:0] A_SEARCH_H   = 8'hB1;
   localparam logic [7:0] A_SEARCH_M   = 8'hB3;
   localparam logic [7:0] A_SEARCH_L   = 8'hB5;
   localparam logic [7:0] A_PROGRAM    = 8'hB7;
   localparam logic [7:0] BCAST_MASK   = 8'hFE;

   localparam logic [15:0] RATE_LIMIT    = 16'd80;
   localparam logic [31:0] RATE_WINDOW   = 32'd1000;
   localparam logic [7:0]  COMPARE_LIMIT = 8'd96;
   localparam logic [31:0] STUCK_CRIT    = 32'd5000;
   localparam logic [31:0] STUCK_MIN     = 32'd500;
   localparam logic [31:0] REPLY_GAP     = 32'd4;

   // commissioning sequence position
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_INIT   = 3'd1,
      PH_RAND   = 3'd2,
      PH_SEARCH = 3'd3,
      PH_PROG   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] now_ms;
      logic [10:0] minute_now;
      logic [15:0] frame_bits;
      logic [5:0]  frame_len;
      logic        frame_clean;
      logic [7:0]  quality;
      logic [7:0]  clash_score;
      logic [1:0]  bus_side;
      logic        line_low;
      logic [31:0] loss_count;
   } req_word_type;

   typedef struct packed {
      logic [3:0]  finding_code;
      logic [1:0]  severity;
      logic [31:0] stamp_ms;
      logic [31:0] evidence_word;
      logic [15:0] context_word;
      logic [1:0]  finding_side;
      logic        last;
   } rsp_word_type;

   // one finding slot as classified by the front end
   typedef struct packed {
      logic        valid;
      logic [3:0]  code;
      logic [1:0]  sev;
      logic [15:0] ctx;
   } slot_type;

   // classified event handed from front to back
   typedef struct packed {
      slot_type [MaxFindings-1:0] slots;
      logic [31:0]                stamp;
      logic [31:0]                evidence;
      logic [1:0]                 side;
   } job_type;

endpackage

@@ rtl/core/lbfam_front.sv @@
// lbfam_front: accepts events, updates monitor state and classifies findings
// depends on lbfam_pkg
`timescale 1ns / 1ps
module lbfam_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [0:0]             csr_addr,
   input  logic [10:0]            csr_wdata,
   input  logic                   take,
   input  lbfam_pkg::req_word_type req,
   output logic                   job_valid,
   output lbfam_pkg::job_type     job
);
   import lbfam_pkg::*;

   logic [10:0] win_start_ff, win_start_in, win_end_ff, win_end_in;
   logic [31:0] rate_start_ff, rate_start_in;
   logic [15:0] frames_ff, frames_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  cmp_ff, cmp_in;
   logic [15:0] reply_frame_ff, reply_frame_in;
   logic [31:0] reply_time_ff, reply_time_in;
   logic [1:0]  low_flag_ff, low_flag_in;
   logic [31:0] low_start_ff [2];
   logic [31:0] low_start_in [2];

   slot_type [MaxFindings-1:0] sl;
   logic [2:0] n;
   logic [10:0] wr_val;
   logic in_win;
   logic [7:0] addr, data;
   logic [31:0] rs, dt;
   logic k;
   logic [31:0] d;

   always_comb begin
      wr_val = (csr_wdata >= MinutesPerDay) ? csr_wdata - MinutesPerDay : csr_wdata;
   end

   always_comb begin
      if (win_start_ff == win_end_ff) in_win = 1'b1;
      else if (win_start_ff < win_end_ff)
         in_win = req.minute_now >= win_start_ff && req.minute_now < win_end_ff;
      else in_win = req.minute_now >= win_start_ff || req.minute_now < win_end_ff;
   end

   always_comb begin
      win_start_in = win_start_ff;
      win_end_in = win_end_ff;
      if (csr_we) begin
         if (csr_addr == CSR_WIN_START) win_start_in = wr_val;
         else win_end_in = wr_val;
      end
   end

   always_comb begin
      rate_start_in = rate_start_ff;
      frames_in = frames_ff;
      phase_in = phase_ff;
      cmp_in = cmp_ff;
      reply_frame_in = reply_frame_ff;
      reply_time_in = reply_time_ff;
      low_flag_in = low_flag_ff;
      low_start_in = low_start_ff;
      sl = '0;
      n = '0;
      addr = req.frame_bits[15:8];
      data = req.frame_bits[7:0];
      rs = rate_start_ff;
      dt = '0;
      k = req.bus_side[1];
      d = req.now_ms - low_start_ff[k];
      case (req.req_type)
         REQ_FRAME: begin
            if (rs == '0) rs = req.now_ms;
            dt = req.now_ms - rs;
            if (dt >= RATE_WINDOW) begin
               if (frames_ff > RATE_LIMIT) begin
                  sl[n] = '{1'b1, FC_RATE_HIGH, SEV_MED, frames_ff}; n = n + 3'd1;
               end
               rs = req.now_ms;
               frames_in = 16'd1;
            end else if (frames_ff != 16'hFFFF) frames_in = frames_ff + 16'd1;
            rate_start_in = rs;
            if (!req.frame_clean) begin
               sl[n] = '{1'b1, FC_BAD_FRAMING, SEV_LOW, {8'd0, req.quality}}; n = n + 3'd1;
            end
            if (req.clash_score >= 8'd3) begin
               sl[n] = '{1'b1, FC_COLLISION, SEV_MED, {8'd0, req.clash_score}};
               n = n + 3'd1;
            end
            if (req.frame_clean && req.frame_len == 6'd16 && addr != A_DTR0) begin
               if (addr == A_TERMINATE || addr == A_INITIALISE || addr == A_RANDOMISE
                   || addr == A_COMPARE || addr == A_WITHDRAW || addr == A_SEARCH_H
                   || addr == A_SEARCH_M || addr == A_SEARCH_L || addr == A_PROGRAM)
               begin
                  if (!in_win) begin
                     sl[n] = '{1'b1, FC_OUTSIDE_WIN, SEV_SERIOUS, {8'd0, addr}};
                     n = n + 3'd1;
                  end
                  case (addr)
                     A_INITIALISE: begin
                        phase_in = PH_INIT; cmp_in = '0;
                        sl[n] = '{1'b1, FC_COMM_START, SEV_MED, 16'd0}; n = n + 3'd1;
                     end
                     A_RANDOMISE: begin
                        if (phase_ff != PH_INIT) begin
                           sl[n] = '{1'b1, FC_COMM_SEQUENCE, SEV_SERIOUS, 16'd1};
                           n = n + 3'd1;
                        end
                        phase_in = PH_RAND;
                     end
                     A_SEARCH_H, A_SEARCH_M, A_SEARCH_L: begin
                        if (phase_ff < PH_RAND) begin
                           sl[n] = '{1'b1, FC_COMM_SEQUENCE, SEV_MED, 16'd2}; n = n + 3'd1;
                        end
                        phase_in = PH_SEARCH;
                     end
                     A_COMPARE: begin
                        cmp_in = cmp_ff + 8'd1;
                        if (phase_ff < PH_SEARCH) begin
                           sl[n] = '{1'b1, FC_COMM_SEQUENCE, SEV_MED, 16'd3}; n = n + 3'd1;
                        end
                        if (cmp_in > COMPARE_LIMIT) begin
                           sl[n] = '{1'b1, FC_RATE_HIGH, SEV_MED, {8'd0, cmp_in}};
                           n = n + 3'd1;
                        end
                     end
                     A_PROGRAM: begin
                        if (phase_ff < PH_SEARCH || cmp_ff == '0) begin
                           sl[n] = '{1'b1, FC_COMM_SEQUENCE, SEV_SERIOUS, 16'd4};
                           n = n + 3'd1;
                        end
                        sl[n] = '{1'b1, FC_ADDR_PROG, SEV_SERIOUS, {8'd0, data}};
                        n = n + 3'd1;
                        phase_in = PH_PROG;
                     end
                     A_WITHDRAW: begin
                        if (phase_ff < PH_PROG) begin
                           sl[n] = '{1'b1, FC_COMM_SEQUENCE, SEV_LOW, 16'd5}; n = n + 3'd1;
                        end
                        phase_in = PH_RAND;
                     end
                     default: begin
                        phase_in = PH_IDLE; cmp_in = '0;
                     end
                  endcase
               end else if ((addr & BCAST_MASK) == BCAST_MASK) begin
                  if (!addr[0] || data == 8'h00) begin
                     sl[n] = '{1'b1, FC_BCAST_OFF, SEV_SERIOUS, {8'd0, data}}; n = n + 3'd1;
                  end else if (data == 8'h05) begin
                     sl[n] = '{1'b1, FC_BCAST_MAX, SEV_MED, {8'd0, data}}; n = n + 3'd1;
                  end
               end
            end else if (req.frame_clean && req.frame_len == 6'd8) begin
               if (reply_time_ff != '0 && (req.now_ms - reply_time_ff) < REPLY_GAP
                   && req.frame_bits != reply_frame_ff) begin
                  sl[n] = '{1'b1, FC_REPLY_CLASH, SEV_MED, reply_frame_ff}; n = n + 3'd1;
               end
               reply_time_in = req.now_ms;
               reply_frame_in = req.frame_bits;
            end
         end
         REQ_LINE: begin
            if (req.bus_side == SIDE_CTRL || req.bus_side == SIDE_DEVICE) begin
               if (req.line_low && !low_flag_ff[k]) begin
                  low_flag_in[k] = 1'b1;
                  low_start_in[k] = req.now_ms;
               end else if (!req.line_low && low_flag_ff[k]) begin
                  if (d >= STUCK_MIN) begin
                     sl[0] = '{1'b1, FC_STUCK_LOW, (d >= STUCK_CRIT) ? SEV_CRIT : SEV_SERIOUS,
                               (d[31:16] != '0) ? 16'hFFFF : d[15:0]};
                  end
                  low_flag_in[k] = 1'b0;
               end else if (req.line_low && d == STUCK_CRIT) begin
                  sl[0] = '{1'b1, FC_STUCK_LOW, SEV_CRIT, STUCK_CRIT[15:0]};
               end
            end
         end
         REQ_LOSS: begin
            if (req.loss_count != '0)
               sl[0] = '{1'b1, FC_CAPTURE_LOSS, SEV_SERIOUS,
                         (req.loss_count[31:16] != '0) ? 16'hFFFF : req.loss_count[15:0]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         win_end_ff <= '0;
         rate_start_ff <= '0;
         frames_ff <= '0;
         phase_ff <= PH_IDLE;
         cmp_ff <= '0;
         reply_frame_ff <= '0;
         reply_time_ff <= '0;
         low_flag_ff <= '0;
         low_start_ff[0] <= '0;
         low_start_ff[1] <= '0;
         job_valid <= 1'b0;
      end else begin
         win_start_ff <= win_start_in;
         win_end_ff <= win_end_in;
         job_valid <= 1'b0;
         if (take) begin
            rate_start_ff <= rate_start_in;
            frames_ff <= frames_in;
            phase_ff <= phase_in;
            cmp_ff <= cmp_in;
            reply_frame_ff <= reply_frame_in;
            reply_time_ff <= reply_time_in;
            low_flag_ff <= low_flag_in;
            low_start_ff <= low_start_in;
            job_valid <= sl[0].valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job.slots <= sl;
         job.stamp <= req.now_ms;
         job.evidence <= (req.req_type == REQ_LINE) ? 32'd0 :
                         (req.req_type == REQ_LOSS) ? req.loss_count :
                         {16'd0, req.frame_bits};
         job.side <= (req.req_type == REQ_LOSS) ? 2'd0 : req.bus_side;
      end
   end

endmodule

@@ rtl/core/lbfam_back.sv @@
// lbfam_back: job queue and serialiser, one finding word per pop
// depends on lbfam_pkg
`timescale 1ns / 1ps
module lbfam_back #(
   parameter int unsigned Depth = lbfam_pkg::QueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   input  lbfam_pkg::job_type      job,
   output logic                    busy_full,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output lbfam_pkg::rsp_word_type rsp_data
);
   import lbfam_pkg::*;

   localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

   job_type mem [Depth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [2:0]    idx_ff, idx_in;
   job_type       head;
   logic          pop_ok, last_slot, done;

   assign head = mem[rp_ff];
   assign rsp_empty = (cnt_ff == '0);
   assign pop_ok = rsp_pop && !rsp_empty;
   // slots are packed from zero, so the next empty one ends the job
   assign last_slot = (idx_ff == 3'(MaxFindings - 1)) || !head.slots[idx_ff + 3'd1].valid;
   assign done = pop_ok && last_slot;
   // leave a spare entry for the word already in the front register
   assign busy_full = (cnt_ff >= (AW + 1)'(Depth - 1));

   always_comb begin
      rsp_data.finding_code = head.slots[idx_ff].code;
      rsp_data.severity = head.slots[idx_ff].sev;
      rsp_data.stamp_ms = head.stamp;
      rsp_data.evidence_word = head.evidence;
      rsp_data.context_word = head.slots[idx_ff].ctx;
      rsp_data.finding_side = head.side;
      rsp_data.last = last_slot;
   end

   always_comb begin
      wp_in = job_valid ? ((wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in = done ? ((rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW + 1)'(job_valid) - (AW + 1)'(done);
      idx_in = done ? 3'd0 : (pop_ok ? idx_ff + 3'd1 : idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_valid) mem[wp_ff] <= job;
   end

endmodule

@@ rtl/core/lighting_bus_frame_anomaly_monitor.sv @@
// channel | ports                         | word
// request | req_push, req_full, req_data  | one bus event
// result  | rsp_pop, rsp_empty, rsp_data  | one finding, last marks end of event
// config  | csr_we, csr_addr, csr_wdata   | window minute registers
// an event is taken when req_push is high and req_full low (one per cycle while not full);
// if it raises findings its job is registered in the front end, then enters the queue;
// the queue head is serialised onto rsp_data. findings leave one per cycle while rsp_pop
// is high, one pop each (one to five per event); events raising none never enter the queue.
// synchronous active-high reset clears state, registers and queue.
// req_full is high while Depth-1 or more jobs wait (three by default), keeping a spare
// entry for the job in flight; result stalls reach the input only through it.
// depends on lbfam_pkg, lbfam_front, lbfam_back
`timescale 1ns / 1ps
module lighting_bus_frame_anomaly_monitor #(
   parameter int unsigned Depth = lbfam_pkg::QueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  lbfam_pkg::req_word_type req_data,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output lbfam_pkg::rsp_word_type rsp_data,
   input  logic                    csr_we,
   input  logic [0:0]              csr_addr,
   input  logic [10:0]             csr_wdata
);
   import lbfam_pkg::*;

   logic    take, job_valid;
   job_type job;

   assign take = req_push && !req_full;

   lbfam_front u_front (
      .clock, .reset, .csr_we, .csr_addr, .csr_wdata,
      .take, .req(req_data), .job_valid, .job
   );

   lbfam_back #(.Depth(Depth)) u_back (
      .clock, .reset, .job_valid, .job, .busy_full(req_full),
      .rsp_empty, .rsp_pop, .rsp_data
   );

`ifndef SYNTHESIS
   a_no_job_when_full: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !take) else $error("event taken while full");
   a_job_follows_take: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> $past(take)) else $error("job without accepted event");
   a_stamp_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data.stamp_ms))
      else $error("result stamp moved under stall");
`endif

endmodule

@@ bench/lbfam_checker.sv @@
// lbfam_checker: watches the event, finding and window register ports of the monitor,
// predicts every finding from the accepted events and compares in order
// depends on lbfam_pkg
`timescale 1ns / 1ps
module lbfam_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic                    req_full,
   input  lbfam_pkg::req_word_type req_data,
   input  logic                    rsp_pop,
   input  logic                    rsp_empty,
   input  lbfam_pkg::rsp_word_type rsp_data,
   input  logic                    csr_we,
   input  logic [0:0]              csr_addr,
   input  logic [10:0]             csr_wdata,
   output int                      fails,
   output int                      pending
);
   import lbfam_pkg::*;

   logic [10:0] win_start, win_end;
   logic [31:0] rate_start;
   logic [15:0] frame_cnt;
   logic [2:0]  comm_phase;
   logic [7:0]  cmp_cnt;
   logic [15:0] reply_frame;
   logic [31:0] reply_time;
   logic        low_on [2];
   logic [31:0] low_t [2];

   logic [31:0]  cur_stamp;
   rsp_word_type fresh[$];
   rsp_word_type findings_due[$];

   initial begin
      fails = 0;
      pending = 0;
   end

   task automatic report(input string msg);
      $display("lbfam_checker: mismatch at %0t: %s", $realtime, msg);
      fails++;
   endtask

   task automatic note(input logic [3:0] code, input logic [1:0] sev, input logic [31:0] ev,
                       input logic [15:0] ctx, input logic [1:0] side);
      rsp_word_type f;
      if (fresh.size() < MaxFindings) begin
         f.finding_code  = code;
         f.severity      = sev;
         f.stamp_ms      = cur_stamp;
         f.evidence_word = ev;
         f.context_word  = ctx;
         f.finding_side  = side;
         f.last          = 1'b0;
         fresh.push_back(f);
      end
   endtask

   function automatic bit minute_open(input logic [10:0] m);
      if (win_start == win_end) return 1'b1;
      if (win_start < win_end) return (m >= win_start) && (m < win_end);
      return (m >= win_start) || (m < win_end);
   endfunction

   task automatic commissioning(input logic [7:0] addr, input logic [7:0] data,
                                input logic [31:0] ev, input logic [10:0] m,
                                input logic [1:0] side);
      if (!minute_open(m)) note(FC_OUTSIDE_WIN, SEV_SERIOUS, ev, {8'd0, addr}, side);
      case (addr)
         A_INITIALISE: begin
            comm_phase = PH_INIT;
            cmp_cnt = 8'd0;
            note(FC_COMM_START, SEV_MED, ev, 16'd0, side);
         end
         A_RANDOMISE: begin
            if (comm_phase != PH_INIT) note(FC_COMM_SEQUENCE, SEV_SERIOUS, ev, 16'd1, side);
            comm_phase = PH_RAND;
         end
         A_SEARCH_H, A_SEARCH_M, A_SEARCH_L: begin
            if (comm_phase < PH_RAND) note(FC_COMM_SEQUENCE, SEV_MED, ev, 16'd2, side);
            comm_phase = PH_SEARCH;
         end
         A_COMPARE: begin
            cmp_cnt = cmp_cnt + 8'd1;
            if (comm_phase < PH_SEARCH) note(FC_COMM_SEQUENCE, SEV_MED, ev, 16'd3, side);
            if (cmp_cnt > COMPARE_LIMIT) note(FC_RATE_HIGH, SEV_MED, ev, {8'd0, cmp_cnt}, side);
         end
         A_PROGRAM: begin
            if (comm_phase < PH_SEARCH || cmp_cnt == 8'd0)
               note(FC_COMM_SEQUENCE, SEV_SERIOUS, ev, 16'd4, side);
            note(FC_ADDR_PROG, SEV_SERIOUS, ev, {8'd0, data}, side);
            comm_phase = PH_PROG;
         end
         A_WITHDRAW: begin
            if (comm_phase < PH_PROG) note(FC_COMM_SEQUENCE, SEV_LOW, ev, 16'd5, side);
            comm_phase = PH_RAND;
         end
         A_TERMINATE: begin
            comm_phase = PH_IDLE;
            cmp_cnt = 8'd0;
         end
         default: ;
      endcase
   endtask

   task automatic predict_findings(input req_word_type w);
      logic [31:0] ev, gap, span;
      logic [7:0]  addr, data;
      int          k;
      fresh.delete();
      cur_stamp = w.now_ms;
      ev = {16'd0, w.frame_bits};
      addr = w.frame_bits[15:8];
      data = w.frame_bits[7:0];
      case (w.req_type)
         REQ_FRAME: begin
            if (rate_start == 32'd0) rate_start = w.now_ms;
            gap = w.now_ms - rate_start;
            if (gap >= RATE_WINDOW) begin
               if (frame_cnt > RATE_LIMIT) note(FC_RATE_HIGH, SEV_MED, ev, frame_cnt, w.bus_side);
               rate_start = w.now_ms;
               frame_cnt = 16'd0;
            end
            if (frame_cnt != 16'hFFFF) frame_cnt++;
            if (!w.frame_clean) note(FC_BAD_FRAMING, SEV_LOW, ev, {8'd0, w.quality}, w.bus_side);
            if (w.clash_score >= 8'd3)
               note(FC_COLLISION, SEV_MED, ev, {8'd0, w.clash_score}, w.bus_side);
            if (w.frame_clean && w.frame_len == 6'd16 && addr != A_DTR0) begin
               case (addr)
                  A_TERMINATE, A_INITIALISE, A_RANDOMISE, A_COMPARE, A_WITHDRAW,
                  A_SEARCH_H, A_SEARCH_M, A_SEARCH_L, A_PROGRAM:
                     commissioning(addr, data, ev, w.minute_now, w.bus_side);
                  default: begin
                     // broadcast address: off when not a command or data zero, else max when data is 05
                     if ((addr & BCAST_MASK) == BCAST_MASK) begin
                        if (!addr[0] || data == 8'h00)
                           note(FC_BCAST_OFF, SEV_SERIOUS, ev, {8'd0, data}, w.bus_side);
                        else if (data == 8'h05)
                           note(FC_BCAST_MAX, SEV_MED, ev, {8'd0, data}, w.bus_side);
                     end
                  end
               endcase
            end else if (w.frame_clean && w.frame_len == 6'd8) begin
               gap = w.now_ms - reply_time;
               if (reply_time != 32'd0 && gap < REPLY_GAP && w.frame_bits != reply_frame)
                  note(FC_REPLY_CLASH, SEV_MED, ev, reply_frame, w.bus_side);
               reply_time = w.now_ms;
               reply_frame = w.frame_bits;
            end
         end
         REQ_LINE: begin
            if (w.bus_side == SIDE_CTRL || w.bus_side == SIDE_DEVICE) begin
               k = int'(w.bus_side) - 1;
               span = w.now_ms - low_t[k];
               if (w.line_low && !low_on[k]) begin
                  low_on[k] = 1'b1;
                  low_t[k] = w.now_ms;
               end else if (!w.line_low && low_on[k]) begin
                  if (span >= STUCK_MIN)
                     note(FC_STUCK_LOW, (span >= STUCK_CRIT) ? SEV_CRIT : SEV_SERIOUS, 32'd0,
                          (span > 32'hFFFF) ? 16'hFFFF : span[15:0], w.bus_side);
                  low_on[k] = 1'b0;
               end else if (w.line_low && span == STUCK_CRIT) begin
                  note(FC_STUCK_LOW, SEV_CRIT, 32'd0, STUCK_CRIT[15:0], w.bus_side);
               end
            end
         end
         REQ_LOSS: begin
            if (w.loss_count != 32'd0)
               note(FC_CAPTURE_LOSS, SEV_SERIOUS, w.loss_count,
                    (w.loss_count > 32'hFFFF) ? 16'hFFFF : w.loss_count[15:0], 2'd0);
         end
         default: ;
      endcase
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) findings_due.push_back(fresh[i]);
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         win_start = 11'd0; win_end = 11'd0;
         rate_start = 32'd0; frame_cnt = 16'd0;
         comm_phase = PH_IDLE; cmp_cnt = 8'd0;
         reply_frame = 16'd0; reply_time = 32'd0;
         low_on[0] = 1'b0; low_on[1] = 1'b0;
         low_t[0] = 32'd0; low_t[1] = 32'd0;
         findings_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_addr == CSR_WIN_START) win_start = csr_wdata % MinutesPerDay;
            else win_end = csr_wdata % MinutesPerDay;
         end
         if (rsp_pop && !rsp_empty) begin
            if (findings_due.size() == 0) begin
               report($sformatf("unexpected finding %p", rsp_data));
            end else begin
               want = findings_due.pop_front();
               check_field("finding_code", rsp_data.finding_code, want.finding_code);
               check_field("severity", rsp_data.severity, want.severity);
               check_field("stamp_ms", rsp_data.stamp_ms, want.stamp_ms);
               check_field("evidence_word", rsp_data.evidence_word, want.evidence_word);
               check_field("context_word", rsp_data.context_word, want.context_word);
               check_field("finding_side", rsp_data.finding_side, want.finding_side);
               check_field("last", rsp_data.last, want.last);
            end
         end
         if (req_push && !req_full) predict_findings(req_data);
      end
      pending = findings_due.size();
   end

endmodule

@@ bench/tb_top.sv @@
// tb_top: drives bus events, window register writes and result pops into the monitor
// under several idling phases; verdict comes from lbfam_checker
// depends on lbfam_pkg, lbfam_checker, lighting_bus_frame_anomaly_monitor
`timescale 1ns / 1ps
module tb_top;
   import lbfam_pkg::*;

   localparam logic [1:0] REQ_NONE  = 2'd3;
   localparam int         LIMIT     = 400000;

   logic         clock, reset;
   logic         req_push, req_full;
   req_word_type req_data;
   logic         rsp_empty, rsp_pop;
   rsp_word_type rsp_data;
   logic         csr_we;
   logic [0:0]   csr_addr;
   logic [10:0]  csr_wdata;
   int           fails, pending;
   int           cycles;
   int           tx_idle_pct, rx_stall_pct;
   bit           hold_req;
   logic [31:0]  t_now;
   int           sent;

   lighting_bus_frame_anomaly_monitor dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   lbfam_checker u_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .fails(fails), .pending(pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // result side: random stalls, and a long hold-off on request
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_pop <= 1'b0;
            hold_req = 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_pop <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   function automatic req_word_type base_word(input logic [1:0] kind);
      req_word_type w;
      w = {$urandom, $urandom, $urandom, $urandom};
      w.req_type = kind;
      w.now_ms = t_now;
      w.minute_now = $urandom_range(2047);
      w.bus_side = $urandom_range(3);
      w.frame_clean = ($urandom_range(9) != 0);
      w.clash_score = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(2);
      w.loss_count = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
      return w;
   endfunction

   task automatic advance_time();
      case ($urandom_range(49))
         0:       t_now = $urandom;
         1, 2, 3: t_now = t_now + $urandom_range(900, 1200);
         default: t_now = t_now + $urandom_range(0, 5);
      endcase
   endtask

   task automatic send(input req_word_type w);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (w.req_type != REQ_NONE) sent++;
   endtask

   task automatic send_frame(input logic [7:0] addr, input logic [7:0] data, input logic [5:0] bits);
      req_word_type w;
      advance_time();
      w = base_word(REQ_FRAME);
      w.frame_bits = {addr, data};
      w.frame_len = bits;
      send(w);
   endtask

   task automatic send_line(input logic [1:0] side, input logic low, input logic [31:0] at);
      req_word_type w;
      t_now = at;
      w = base_word(REQ_LINE);
      w.bus_side = side;
      w.line_low = low;
      send(w);
   endtask

   task automatic send_clean(input logic [7:0] addr, input logic [7:0] data);
      req_word_type w;
      advance_time();
      w = base_word(REQ_FRAME);
      w.frame_bits = {addr, data};
      w.frame_len = 6'd16;
      w.frame_clean = 1'b1;
      send(w);
   endtask

   task automatic settle_and_write(input logic [10:0] s, input logic [10:0] e);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_we <= 1'b1; csr_addr <= CSR_WIN_START; csr_wdata <= s;
      @(posedge clock);
      csr_addr <= CSR_WIN_END; csr_wdata <= e;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // well-formed commissioning run with random content, sometimes broken
   task automatic commission_run(input int compares);
      logic [7:0] srch [3];
      srch[0] = A_SEARCH_H; srch[1] = A_SEARCH_M; srch[2] = A_SEARCH_L;
      send_clean(A_INITIALISE, $urandom);
      if ($urandom_range(4) != 0) send_clean(A_RANDOMISE, $urandom);
      send_clean(srch[$urandom_range(2)], $urandom);
      repeat (compares) send_clean(A_COMPARE, $urandom);
      send_clean(A_PROGRAM, $urandom);
      if ($urandom_range(1)) send_clean(A_WITHDRAW, $urandom);
      if ($urandom_range(1)) send_clean(A_DTR0, $urandom);
      send_clean(A_TERMINATE, $urandom);
   endtask

   task automatic random_item();
      req_word_type w;
      logic [7:0]   addrs [12];
      logic [31:0]  t0;
      logic [1:0]   side;
      addrs = '{A_TERMINATE, A_DTR0, A_INITIALISE, A_RANDOMISE, A_COMPARE, A_WITHDRAW,
                A_SEARCH_H, A_SEARCH_M, A_SEARCH_L, A_PROGRAM, 8'hFE, 8'hFF};
      case ($urandom_range(9))
         0, 1, 2: commission_run($urandom_range(0, 4));
         3: begin
            side = $urandom_range(1) ? SIDE_CTRL : SIDE_DEVICE;
            t0 = t_now + $urandom_range(1, 20);
            send_line(side, 1'b1, t0);
            if ($urandom_range(1)) send_line(side, 1'b1, t0 + STUCK_CRIT);
            send_line(side, $urandom_range(3) == 0,
                      t0 + (($urandom_range(1)) ? $urandom_range(0, 900) : $urandom_range(4990, 70000)));
         end
         4: begin
            advance_time();
            send(base_word(REQ_LOSS));
         end
         5: begin
            advance_time();
            w = base_word($urandom_range(3) == 0 ? REQ_NONE : REQ_LINE);
            send(w);
         end
         6: send_frame($urandom, $urandom, $urandom_range(1) ? 6'd8 : 6'($urandom_range(32)));
         default: send_frame(($urandom_range(2) == 0) ? 8'($urandom) : addrs[$urandom_range(11)],
                             ($urandom_range(2) == 0) ? 8'($urandom_range(5)) : 8'($urandom),
                             ($urandom_range(5) == 0) ? 6'd8 : 6'd16);
      endcase
   endtask

   task automatic directed();
      req_word_type w;
      t_now = 32'd0;
      send_clean(8'hFF, 8'h00);
      send_clean(8'hFE, 8'h42);
      send_clean(8'hFF, 8'h05);
      send_clean(A_DTR0, 8'hFF);
      send_clean(A_PROGRAM, 8'hFF);
      send_clean(A_WITHDRAW, 8'h00);
      send_clean(A_RANDOMISE, 8'h00);
      commission_run(2);
      w = base_word(REQ_FRAME);
      w.frame_bits = 16'hFFFF; w.frame_len = 6'd16; w.frame_clean = 1'b0;
      w.quality = 8'hFF; w.clash_score = 8'hFF; w.bus_side = 2'd3;
      send(w);
      send_frame(8'hFF, 8'hFF, 6'd32);
      send_frame(8'h12, 8'h34, 6'd0);
      // two differing replies close together
      w = base_word(REQ_FRAME);
      w.frame_len = 6'd8; w.frame_clean = 1'b1; w.frame_bits = 16'h00AA; w.now_ms = t_now + 100;
      send(w);
      w.frame_bits = 16'h0055; w.now_ms = t_now + 103;
      send(w);
      t_now = t_now + 103;
      send_line(SIDE_CTRL, 1'b1, t_now + 10);
      send_line(SIDE_CTRL, 1'b1, t_now + STUCK_CRIT);
      send_line(SIDE_CTRL, 1'b0, t_now + 900);
      send_line(SIDE_DEVICE, 1'b1, t_now + 1);
      send_line(SIDE_DEVICE, 1'b0, t_now + 600);
      send_line(2'd0, 1'b1, t_now + 1);
      w = base_word(REQ_LOSS);
      w.loss_count = 32'd0; send(w);
      w.loss_count = 32'hFFFF_FFFF; send(w);
      w.loss_count = 32'd7; send(w);
      w = base_word(REQ_NONE); send(w);
   endtask

   initial begin
      cycles = 0; sent = 0; hold_req = 1'b0; t_now = 32'd0;
      tx_idle_pct = 0; rx_stall_pct = 0;
      reset = 1'b1; req_push = 1'b0; req_data = '0;
      csr_we = 1'b0; csr_addr = CSR_WIN_START; csr_wdata = 11'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      settle_and_write(11'd0, 11'd0);
      directed();

      // no idling, then the result side holds off while events keep coming
      settle_and_write(11'd1439, 11'd0);
      hold_req = 1'b1;
      repeat (30) send_frame(8'hFF, 8'h00, 6'd16);
      while (sent < 120) random_item();

      settle_and_write(11'd100, 11'd1439);
      tx_idle_pct = 70;
      commission_run(100);
      while (sent < 240) random_item();

      settle_and_write(11'd2047, 11'd2047);
      tx_idle_pct = 0; rx_stall_pct = 70;
      while (sent < 330) random_item();

      settle_and_write(11'd600, 11'd200);
      tx_idle_pct = 15; rx_stall_pct = 15;
      while (sent < 415) random_item();

      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fails == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
